[hdl/appd_pkg.sv]
// ----------------------------------------------------------------------------
// appd_pkg
// Shared types and constants of the adaptive peak pulse detector.
// ----------------------------------------------------------------------------
`default_nettype none

package appd_pkg;

  localparam int FACT_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int HALF_Q16  = 32768;

  localparam logic [FACT_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REFR_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT   = 3'd3;

  localparam logic [15:0]       REFR_RST   = 16'd200;
  localparam logic [FACT_W-1:0] DECAY_RST  = 17'd65536;
  localparam logic [FACT_W-1:0] WEIGHT_RST = 17'd19661;
  localparam int                THR_RST    = 10240;

  typedef enum logic [1:0] {
    MUL_DECAY,
    MUL_INV_W,
    MUL_MAX_W
  } mul_sel_t;

  typedef struct packed {
    logic     load_in;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     test;
    logic     acc_ld;
    logic     blend;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic close;
  } sts_t;

endpackage

`default_nettype wire

[hdl/appd_ctrl.sv]
// ----------------------------------------------------------------------------
// appd_ctrl
// Sequencer: steps one sample through decay, test and optional blend.
// ----------------------------------------------------------------------------
`default_nettype none

module appd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output appd_pkg::cmd_t     cmd,
  input  wire appd_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECAY,
    S_TEST,
    S_MUL_A,
    S_MUL_B,
    S_BLEND,
    S_DONE
  } state_t;

  state_t state_r;
  logic   in_tready_r;
  logic   out_tvalid_r;

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = appd_pkg::MUL_DECAY;
    unique case (state_r)
      S_IDLE:  cmd.load_in = in_tvalid;
      S_DECAY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = appd_pkg::MUL_DECAY;
      end
      S_TEST:  cmd.test = 1'b1;
      S_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = appd_pkg::MUL_INV_W;
      end
      S_MUL_B: begin
        cmd.mul_en  = 1'b1;
        cmd.acc_ld  = 1'b1;
        cmd.mul_sel = appd_pkg::MUL_MAX_W;
      end
      S_BLEND: cmd.blend = 1'b1;
      S_DONE:  cmd.out_ld = !out_tvalid_r || out_tready;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.out_ld) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r     <= S_DECAY;
            in_tready_r <= 1'b0;
          end
        end
        S_DECAY: state_r <= S_TEST;
        S_TEST:  state_r <= sts.close ? S_MUL_A : S_DONE;
        S_MUL_A: state_r <= S_MUL_B;
        S_MUL_B: state_r <= S_BLEND;
        S_BLEND: state_r <= S_DONE;
        S_DONE: begin
          if (cmd.out_ld) begin
            state_r     <= S_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/appd_dp.sv]
// ----------------------------------------------------------------------------
// appd_dp
// Datapath: config registers, shared multiplier, window tracking, result.
// ----------------------------------------------------------------------------
`default_nettype none

module appd_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TIME_WIDTH   = 32,
  parameter int CFG_DW       = 24
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [appd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]              cfg_data,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic [TIME_WIDTH-1:0]          now_in,
  input  wire appd_pkg::cmd_t                 cmd,
  output appd_pkg::sts_t                      sts,
  output logic                                pulse_out,
  output logic signed [SAMPLE_WIDTH-1:0]      thr_out,
  output logic [TIME_WIDTH-1:0]               peak_time_out
);

  localparam int S  = SAMPLE_WIDTH;
  localparam int FW = appd_pkg::FACT_W;
  localparam int PW = S + FW + 1;
  localparam int SW = PW + 1;

  logic [15:0]       refr_r;
  logic [FW-1:0]     decay_r;
  logic [FW-1:0]     weight_r;

  logic signed [S-1:0]  thr_r;
  logic [TIME_WIDTH-1:0] last_peak_r;
  logic signed [S-1:0]  wmax_r;
  logic [TIME_WIDTH-1:0] wmax_ms_r;
  logic                 in_win_r;

  logic signed [S-1:0]  sample_r;
  logic [TIME_WIDTH-1:0] now_r;

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;

  logic pulse_r;
  logic pulse_o_r;
  logic signed [S-1:0]  thr_o_r;
  logic [TIME_WIDTH-1:0] peak_o_r;

  logic [FW-1:0]         decay_sat;
  logic [FW-1:0]         w_sat;
  logic signed [S-1:0]   mul_a;
  logic signed [FW:0]    mul_f;
  logic signed [PW-1:0]  prod_nxt;
  logic signed [PW-1:0]  dec_rnd;
  logic signed [S-1:0]   thr_dec;
  logic signed [SW-1:0]  blend_sum;
  logic [TIME_WIDTH-1:0] since;
  logic                  open_cond;

  assign decay_sat = (decay_r > appd_pkg::ONE_Q16) ? appd_pkg::ONE_Q16 : decay_r;
  assign w_sat     = (weight_r > appd_pkg::ONE_Q16) ? appd_pkg::ONE_Q16 : weight_r;

  always_comb begin
    case (cmd.mul_sel)
      appd_pkg::MUL_DECAY: begin
        mul_a = thr_r;
        mul_f = $signed({1'b0, decay_sat});
      end
      appd_pkg::MUL_INV_W: begin
        mul_a = thr_r;
        mul_f = $signed({1'b0, appd_pkg::ONE_Q16 - w_sat});
      end
      appd_pkg::MUL_MAX_W: begin
        mul_a = wmax_r;
        mul_f = $signed({1'b0, w_sat});
      end
      default: begin
        mul_a = thr_r;
        mul_f = $signed({1'b0, decay_sat});
      end
    endcase
  end

  assign prod_nxt  = PW'(mul_a) * PW'(mul_f);
  assign dec_rnd   = prod_r + PW'(appd_pkg::HALF_Q16);
  assign thr_dec   = dec_rnd[S+15:16];
  assign blend_sum = SW'(acc_r) + SW'(prod_r) + SW'(appd_pkg::HALF_Q16);
  assign since     = now_r - last_peak_r;
  assign open_cond = (sample_r > thr_dec) && (since > TIME_WIDTH'(refr_r));

  assign sts.close = !open_cond && in_win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refr_r      <= appd_pkg::REFR_RST;
      decay_r     <= appd_pkg::DECAY_RST;
      weight_r    <= appd_pkg::WEIGHT_RST;
      thr_r       <= S'(appd_pkg::THR_RST);
      last_peak_r <= '0;
      wmax_r      <= '0;
      wmax_ms_r   <= '0;
      in_win_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          appd_pkg::REG_INIT_THR: thr_r    <= cfg_data[S-1:0];
          appd_pkg::REG_REFR_MS:  refr_r   <= cfg_data[15:0];
          appd_pkg::REG_DECAY:    decay_r  <= cfg_data[FW-1:0];
          appd_pkg::REG_WEIGHT:   weight_r <= cfg_data[FW-1:0];
          default: ;
        endcase
      end
      if (cmd.test) begin
        thr_r <= thr_dec;
        if (open_cond) begin
          if (!in_win_r || (sample_r > wmax_r)) begin
            wmax_r    <= sample_r;
            wmax_ms_r <= now_r;
          end
          in_win_r <= 1'b1;
        end else if (in_win_r) begin
          in_win_r    <= 1'b0;
          last_peak_r <= wmax_ms_r;
        end
      end
      if (cmd.blend) begin
        thr_r <= blend_sum[S+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= sample_in;
      now_r    <= now_in;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc_ld) begin
      acc_r <= prod_r;
    end
    if (cmd.test) begin
      pulse_r <= sts.close;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      pulse_o_r <= pulse_r;
      thr_o_r   <= thr_r;
      peak_o_r  <= last_peak_r;
    end
  end

  assign pulse_out     = pulse_o_r;
  assign thr_out       = thr_o_r;
  assign peak_time_out = peak_o_r;

endmodule

`default_nettype wire

[hdl/adaptive_peak_pulse_detector.sv]
// ----------------------------------------------------------------------------
// adaptive_peak_pulse_detector
// Adaptive-threshold peak detector for a filtered cardiogram sample stream.
//
// Input beats carry one sample and its millisecond timestamp; every input
// beat yields exactly one output beat with the pulse flag (tuser), the
// updated threshold and the time of the last confirmed peak.
// After the input beat is accepted, the sequencer runs decay, test and, on
// a window close, two extra products and a sum through one shared 24x18
// multiplier before out_tvalid rises. in_tready is high only while the
// sequencer is idle, so no new sample is taken until the last result has
// been loaded into the output register. The result sits in an output
// register; the next sample is accepted and processed while it waits, and
// the sequencer holds in its final step only if that register is still
// occupied and not being drained. Reset (synchronous, rst_n low) loads the
// register defaults, sets the threshold to 40.0 and clears window and peak
// state; no clearing pass. Configuration beats are always accepted; a write
// to register 0 also loads the working threshold. The user must let writes
// go in only while the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_peak_pulse_detector #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int TIME_WIDTH   = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [SAMPLE_WIDTH-1:0] sample_value, then now_ms, zero padded to bytes
  input  wire logic [((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [SAMPLE_WIDTH-1:0] threshold_out, then peak_time_out, zero padded
  output logic [((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // [0] pulse_found
  output logic                                out_tuser,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [appd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [((SAMPLE_WIDTH > appd_pkg::FACT_W) ? SAMPLE_WIDTH
                                                        : appd_pkg::FACT_W) - 1:0] cfg_data
);

  localparam int IN_TDW  = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDW = ((SAMPLE_WIDTH + TIME_WIDTH + 7) / 8) * 8;
  localparam int CFG_DW  = (SAMPLE_WIDTH > appd_pkg::FACT_W) ? SAMPLE_WIDTH
                                                             : appd_pkg::FACT_W;

  appd_pkg::cmd_t cmd;
  appd_pkg::sts_t sts;

  logic signed [SAMPLE_WIDTH-1:0] thr_out;
  logic [TIME_WIDTH-1:0]          peak_time;

  assign cfg_ready = 1'b1;

  appd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  appd_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TIME_WIDTH   (TIME_WIDTH),
    .CFG_DW       (CFG_DW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_in     (in_tdata[SAMPLE_WIDTH-1:0]),
    .now_in        (in_tdata[SAMPLE_WIDTH+TIME_WIDTH-1:SAMPLE_WIDTH]),
    .cmd           (cmd),
    .sts           (sts),
    .pulse_out     (out_tuser),
    .thr_out       (thr_out),
    .peak_time_out (peak_time)
  );

  assign out_tdata = OUT_TDW'({peak_time, thr_out});

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted twice in a row");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |=> out_tvalid)
    else $error("result load did not raise out_tvalid");

  a_blend_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_ld |=> cmd.blend)
    else $error("blend sum not following accumulator load");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_in, cmd.test, cmd.acc_ld, cmd.blend, cmd.out_ld}))
    else $error("sequencer commands overlap");

endmodule

`default_nettype wire

[test/tb_adaptive_peak_pulse_detector.sv]
// ----------------------------------------------------------------------------
// tb_adaptive_peak_pulse_detector
// Self-checking testbench for the adaptive peak pulse detector.
//
// A directed table steps through threshold ties, refractory edges, window
// maximum tracking and timestamp wrap from the reset defaults. Random phases
// follow, each with fresh register settings that include the range extremes
// and saturating factors. Samples are mostly noise at or below the running
// threshold, with rare bursts over it. Every output beat is checked field by
// field, in order, against typed table rows or the in-bench detector model.
// ----------------------------------------------------------------------------
module tb_adaptive_peak_pulse_detector;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     SW          = 24;
  localparam int     TW          = 32;
  localparam int     IN_TDW      = 56;
  localparam int     OUT_TDW     = 56;
  localparam int     CFG_DW      = 24;
  localparam int     CLK_PERIOD  = 10;
  localparam int     CYCLE_LIMIT = 300000;
  localparam int     HOLD_LEN    = 300;
  localparam int     PHASES      = 13;
  localparam int     PHASE_ITEMS = 110;
  localparam int     DIR_ROWS    = 19;
  localparam longint SMP_MAX     = 8388607;
  localparam longint SMP_MIN     = -8388608;

  localparam logic [appd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd4;

  typedef struct packed {
    logic          pulse;
    logic [SW-1:0] thr;
    logic [TW-1:0] peak_ms;
  } report_t;

  typedef struct {
    logic [SW-1:0] smp;
    logic [TW-1:0] now;
    bit            typed;
    report_t       rep;
  } dir_row_t;

  localparam report_t NO_REP = '0;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [IN_TDW-1:0]              in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [OUT_TDW-1:0]             out_tdata;
  logic                           out_tuser;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [appd_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0]              cfg_data   = '0;

  // detector model state and register copies
  logic signed [SW-1:0]        thr_st;
  logic signed [SW-1:0]        max_st;
  logic [TW-1:0]               last_peak_st;
  logic [TW-1:0]               max_ms_st;
  logic                        open_st;
  logic signed [SW-1:0]        init_thr_r;
  logic [15:0]                 refr_r;
  logic [appd_pkg::FACT_W-1:0] decay_r;
  logic [appd_pkg::FACT_W-1:0] weight_r;

  report_t     pending_reports[$];
  int          err_count     = 0;
  int          beat_count    = 0;
  int          cycle_count   = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int          hold_left     = 0;
  bit          tx_idle_en    = 1'b1;
  bit          rx_idle_en    = 1'b1;
  int          burst_left    = 0;
  logic [TW-1:0] t_now       = 32'd1000;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{24'd0,       32'd0,          1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'd10240,   32'd1000,       1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'd10241,   32'd200,        1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'd10241,   32'd201,        1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'h7FFFFF,  32'd202,        1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'h7FFFFF,  32'd203,        1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'd20000,   32'd204,        1'b1, '{1'b0, 24'd10240, 32'd0}},
    '{24'h800000,  32'd205,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'd300,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'd403,        1'b0, NO_REP},
    '{24'd0,       32'd404,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'hFFFF_FFFF,  1'b0, NO_REP},
    '{24'd0,       32'd0,          1'b0, NO_REP},
    '{24'h7FFFFF,  32'd200,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'd201,        1'b0, NO_REP},
    '{24'hFFFFFF,  32'd202,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'd400,        1'b0, NO_REP},
    '{24'h7FFFFF,  32'd401,        1'b0, NO_REP},
    '{24'h800000,  32'd402,        1'b0, NO_REP}
  };

  adaptive_peak_pulse_detector #(
    .SAMPLE_WIDTH(SW),
    .TIME_WIDTH  (TW)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  function automatic longint sat_q16(logic [appd_pkg::FACT_W-1:0] f);
    return (f > appd_pkg::ONE_Q16) ? longint'(appd_pkg::ONE_Q16) : longint'(f);
  endfunction

  // round to nearest, halves up
  function automatic logic signed [SW-1:0] round_q16(longint p);
    longint q;
    q = (p + appd_pkg::HALF_Q16) >>> 16;
    return q[SW-1:0];
  endfunction

  function automatic void reset_detector();
    init_thr_r   = SW'(appd_pkg::THR_RST);
    refr_r       = appd_pkg::REFR_RST;
    decay_r      = appd_pkg::DECAY_RST;
    weight_r     = appd_pkg::WEIGHT_RST;
    thr_st       = init_thr_r;
    max_st       = '0;
    last_peak_st = '0;
    max_ms_st    = '0;
    open_st      = 1'b0;
  endfunction

  function automatic void apply_register(logic [appd_pkg::CFG_IDX_W-1:0] idx,
                                         logic [CFG_DW-1:0] data);
    case (idx)
      appd_pkg::REG_INIT_THR: begin
        init_thr_r = data[SW-1:0];
        thr_st     = data[SW-1:0];
      end
      appd_pkg::REG_REFR_MS: refr_r   = data[15:0];
      appd_pkg::REG_DECAY:   decay_r  = data[appd_pkg::FACT_W-1:0];
      appd_pkg::REG_WEIGHT:  weight_r = data[appd_pkg::FACT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic report_t step_detector(logic signed [SW-1:0] smp, logic [TW-1:0] now);
    report_t       r;
    logic [TW-1:0] since;
    longint        w;
    r.pulse = 1'b0;
    since   = now - last_peak_st;
    thr_st  = round_q16(longint'(thr_st) * sat_q16(decay_r));
    if (smp > thr_st && since > TW'(refr_r)) begin
      if (!open_st || smp > max_st) begin
        max_st    = smp;
        max_ms_st = now;
      end
      open_st = 1'b1;
    end else if (open_st) begin
      w            = sat_q16(weight_r);
      open_st      = 1'b0;
      last_peak_st = max_ms_st;
      thr_st       = round_q16((longint'(appd_pkg::ONE_Q16) - w) * longint'(thr_st)
                               + w * longint'(max_st));
      r.pulse      = 1'b1;
    end
    r.thr     = thr_st;
    r.peak_ms = last_peak_st;
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    if (err_count < 100) $display("[%0t] beat %0d: %s", $realtime, beat_count, msg);
    err_count++;
  endtask

  task automatic write_register(logic [appd_pkg::CFG_IDX_W-1:0] idx,
                                logic [CFG_DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [SW-1:0] smp, logic [TW-1:0] now, bit typed,
                             report_t typed_rep);
    report_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= {now, smp};
    do @(posedge clk); while (!in_tready);
    r = step_detector(smp, now);
    pending_reports.push_back(typed ? typed_rep : r);
    if (tx_idle_en && $urandom_range(0, 99) < 40) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 60);
    end
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic random_sample(output logic [SW-1:0] smp, output logic [TW-1:0] now);
    longint v;
    int     sel;
    sel = $urandom_range(0, 99);
    if (sel < 85)      t_now += $urandom_range(1, 40);
    else if (sel < 93) t_now += $urandom_range(100, 400);
    else if (sel < 97) t_now += $urandom_range(60000, 70000);
    else               t_now = $urandom;
    now = t_now;
    if ($urandom_range(0, 99) < 10) begin
      smp = SW'($urandom);
    end else begin
      if (burst_left > 0) begin
        v = longint'(thr_st) + longint'($urandom_range(1, 4000));
        burst_left--;
      end else begin
        if ($urandom_range(0, 99) < 10) burst_left = $urandom_range(1, 6);
        v = longint'(thr_st) - longint'($urandom_range(0, 4000));
      end
      if (v > SMP_MAX) v = SMP_MAX;
      if (v < SMP_MIN) v = SMP_MIN;
      smp = v[SW-1:0];
    end
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_tready  <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_LEN;
    end else begin
      out_tready <= !(rx_idle_en && $urandom_range(0, 99) < 19);
    end
  end

  always @(posedge clk) begin
    report_t want;
    if (out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("output beat with no sample pending");
      end else begin
        want = pending_reports.pop_front();
        if (out_tuser !== want.pulse)
          flag_mismatch($sformatf("pulse_found got %b want %b", out_tuser, want.pulse));
        if (out_tdata[SW-1:0] !== want.thr)
          flag_mismatch($sformatf("threshold_out got %0d want %0d",
                                  $signed(out_tdata[SW-1:0]), $signed(want.thr)));
        if (out_tdata[SW+TW-1:SW] !== want.peak_ms)
          flag_mismatch($sformatf("peak_time_out got %0d want %0d",
                                  out_tdata[SW+TW-1:SW], want.peak_ms));
      end
      beat_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [SW-1:0]               smp;
    logic [TW-1:0]               now;
    logic signed [SW-1:0]        it;
    logic [15:0]                 rf;
    logic [appd_pkg::FACT_W-1:0] dc;
    logic [appd_pkg::FACT_W-1:0] wt;
    reset_detector();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        pause_sender();
        repeat (3) @(posedge clk);
        case (p)
          1: begin
            it = SW'(SMP_MIN);  rf = 16'd0;    dc = appd_pkg::ONE_Q16;  wt = '0;
          end
          2: begin
            it = SW'(SMP_MAX);  rf = 16'hFFFF; dc = '0;  wt = appd_pkg::ONE_Q16;
          end
          3: begin
            it = SW'(-2000);    rf = 16'd150;  dc = 17'd65000;  wt = 17'h1FFFF;
          end
          4: begin
            it = '0;  rf = 16'd0;  dc = 17'h1FFFF;  wt = appd_pkg::WEIGHT_RST;
          end
          5: begin
            it = SW'(5000);     rf = 16'd20;   dc = 17'd65500;  wt = 17'd30000;
          end
          default: begin
            it = SW'($urandom_range(0, 40000) - 20000);
            rf = 16'($urandom_range(0, 300));
            dc = ($urandom_range(0, 3) == 0)
                 ? appd_pkg::FACT_W'($urandom)
                 : appd_pkg::FACT_W'($urandom_range(64000, 65536));
            wt = appd_pkg::FACT_W'($urandom);
          end
        endcase
        write_register(REG_UNUSED + appd_pkg::CFG_IDX_W'($urandom_range(0, 3)),
                       CFG_DW'($urandom));
        write_register(appd_pkg::REG_REFR_MS, {8'($urandom), rf});
        write_register(appd_pkg::REG_DECAY, {7'($urandom), dc});
        write_register(appd_pkg::REG_WEIGHT, {7'($urandom), wt});
        write_register(appd_pkg::REG_INIT_THR, it);
      end
      tx_idle_en = (p != 5);
      rx_idle_en = (p != 5);
      if (p == 0) begin
        foreach (dir_tab[i])
          send_sample(dir_tab[i].smp, dir_tab[i].now, dir_tab[i].typed, dir_tab[i].rep);
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 5 && i == 30) || (p == 9 && i == 40)) hold_requests++;
        if ((p == 3 && i == 55) || (p == 10 && i == 20)) pause_sender();
        random_sample(smp, now);
        send_sample(smp, now, 1'b0, NO_REP);
      end
    end
    pause_sender();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
hdl/appd_pkg.sv
hdl/appd_ctrl.sv
hdl/appd_dp.sv
hdl/adaptive_peak_pulse_detector.sv
test/tb_adaptive_peak_pulse_detector.sv
